/* rtl/lfps_pkg.sv */
// lfps_pkg: types, constants and the sensor pattern table of the line follower
// PD steering and speed controller; used by every other file of the block
`default_nettype none

package lfps_pkg;

	// field widths
	localparam int PATTERN_W = 11;
	localparam int SERVO_W   = 8;
	localparam int DRIVE_W   = 7;
	localparam int ERR_W     = 5;
	localparam int LOST_W    = 15;
	localparam int STRAIGHT_W = 4;
	localparam int GAIN_W    = 7;
	localparam int DGAIN_W   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// shared multiplier operand widths
	localparam int MUL_A_W = 15;
	localparam int MUL_B_W = 14;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// divide by ten as multiply by 3277 / 2^15, exact for magnitudes below 16384
	localparam logic [MUL_B_W-1:0] RECIP_TEN = 14'd3277;
	localparam int RECIP_SHIFT = 15;

	// control constants
	localparam logic signed [9:0] SERVO_CENTRE = 10'sd113;
	localparam logic signed [9:0] SERVO_MAX    = 10'sd158;
	localparam logic signed [9:0] SERVO_MIN    = 10'sd83;
	localparam logic [LOST_W-1:0] LOST_LIMIT   = 15'd75;
	localparam logic [LOST_W-1:0] LOST_SAT     = 15'd32767;
	localparam logic signed [8:0] STEER_LIMIT  = 9'sd35;
	localparam logic signed [8:0] STEER_NEAR   = 9'sd6;
	localparam logic signed [11:0] DRIVE_MAX   = 12'sd100;
	localparam logic [STRAIGHT_W-1:0] STRAIGHT_CAP    = 4'd10;
	localparam logic [STRAIGHT_W-1:0] STRAIGHT_NEEDED = 4'd8;
	localparam logic signed [5:0] JUMP_LIMIT   = 6'sd9;
	localparam logic [ERR_W-1:0] BIG_ERR       = 5'd3;
	localparam logic [7:0] BEND_CUT            = 8'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_SPEED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_KP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_KD    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KP       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KD       = 3'd6;

	// configuration reset values
	localparam logic [DRIVE_W-1:0] RST_STRAIGHT_SPEED = 7'd65;
	localparam logic [DRIVE_W-1:0] RST_CURVE_SPEED    = 7'd55;
	localparam logic [DGAIN_W-1:0] RST_DIFF_GAIN      = 8'd10;
	localparam logic [GAIN_W-1:0]  RST_STRAIGHT_KP    = 7'd25;
	localparam logic [GAIN_W-1:0]  RST_STRAIGHT_KD    = 7'd60;
	localparam logic [GAIN_W-1:0]  RST_CURVE_KP       = 7'd28;
	localparam logic [GAIN_W-1:0]  RST_CURVE_KD       = 7'd70;

	typedef struct packed {
		logic [DRIVE_W-1:0] straight_speed;
		logic [DRIVE_W-1:0] curve_speed;
		logic [DGAIN_W-1:0] differential_gain;
		logic [GAIN_W-1:0]  straight_kp;
		logic [GAIN_W-1:0]  straight_kd;
		logic [GAIN_W-1:0]  curve_kp;
		logic [GAIN_W-1:0]  curve_kd;
	} lfps_cfg_t;

	typedef struct packed {
		logic [SERVO_W-1:0] servo_width;
		logic [DRIVE_W-1:0] left_drive;
		logic [DRIVE_W-1:0] right_drive;
		logic               line_lost;
	} lfps_result_t;

	typedef struct packed {
		logic                    known;
		logic signed [ERR_W-1:0] err;
	} lfps_lookup_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_SUM,
		ST_DIV_PD,
		ST_STEER,
		ST_MUL_DIFF,
		ST_DIV_DIFF,
		ST_DRIVE
	} lfps_state_t;

	// sensor pattern to position error
	function automatic lfps_lookup_t lfps_lookup(input logic [PATTERN_W-1:0] pat);
		lfps_lookup_t r;
		r.known = 1'b1;
		r.err   = '0;
		case (pat)
			11'h400: r.err = -5'sd11;
			11'h600: r.err = -5'sd9;
			11'h200: r.err = -5'sd7;
			11'h300: r.err = -5'sd6;
			11'h100: r.err = -5'sd5;
			11'h180: r.err = -5'sd4;
			11'h080: r.err = -5'sd3;
			11'h0c0: r.err = -5'sd2;
			11'h040: r.err = -5'sd1;
			11'h060: r.err = 5'sd0;
			11'h020: r.err = 5'sd0;
			11'h030: r.err = 5'sd0;
			11'h010: r.err = 5'sd1;
			11'h018: r.err = 5'sd2;
			11'h008: r.err = 5'sd3;
			11'h00c: r.err = 5'sd4;
			11'h004: r.err = 5'sd5;
			11'h006: r.err = 5'sd6;
			11'h002: r.err = 5'sd7;
			11'h003: r.err = 5'sd9;
			11'h001: r.err = 5'sd11;
			default: r.known = 1'b0;
		endcase
		return r;
	endfunction

	// magnitude of a position error
	function automatic logic [ERR_W-1:0] lfps_abs_err(input logic signed [ERR_W-1:0] e);
		return e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
	endfunction

endpackage

`default_nettype wire

/* rtl/lfps_if.sv */
// lfps_sensor_if and lfps_result_if: valid/ready channels of the controller
// depends on lfps_pkg for the field widths
`default_nettype none

interface lfps_sensor_if import lfps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PATTERN_W-1:0] sensor_pattern;

	modport source (output valid, output sensor_pattern, input ready);
	modport sink (input valid, input sensor_pattern, output ready);
endinterface

interface lfps_result_if import lfps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SERVO_W-1:0] servo_width;
	logic [DRIVE_W-1:0] left_drive;
	logic [DRIVE_W-1:0] right_drive;
	logic               line_lost;

	modport source (output valid, output servo_width, output left_drive,
		output right_drive, output line_lost, input ready);
	modport sink (input valid, input servo_width, input left_drive,
		input right_drive, input line_lost, output ready);
endinterface

`default_nettype wire

/* rtl/line_follow_pd_steer_speed.sv */
// line_follow_pd_steer_speed: top level with configuration registers and channels
// depends on lfps_pkg, lfps_if, lfps_core (which uses lfps_mul)
//
// Usage:
// sensor channel carries one 11-bit line sensor pattern per control step.
// result channel returns one item per pattern: servo width, left and right
// drive, and the lost-line flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); index 7 is
// ignored. Users must write it only while no item is in flight; not enforced.
// Sequence: an accepted item runs through the steps in order on a single shared
// multiplier (P term, D term, sum, divide by ten, steer, differential, divide by
// ten, drive). sensor.ready is high only in the idle state between items, so no
// new item is accepted before the last one has finished its drive step.
// A finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the following step holds in its
// last state until the register frees, and sensor.ready stays low.
// Reset (arst_n low, asynchronous) restores the register defaults and clears
// the previous error, lost and straight counters and the result valid.
`default_nettype none

module line_follow_pd_steer_speed import lfps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lfps_sensor_if.sink                sensor,
	lfps_result_if.source              result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	lfps_cfg_t    cfg_q;
	lfps_result_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.straight_speed    <= RST_STRAIGHT_SPEED;
			cfg_q.curve_speed       <= RST_CURVE_SPEED;
			cfg_q.differential_gain <= RST_DIFF_GAIN;
			cfg_q.straight_kp       <= RST_STRAIGHT_KP;
			cfg_q.straight_kd       <= RST_STRAIGHT_KD;
			cfg_q.curve_kp          <= RST_CURVE_KP;
			cfg_q.curve_kd          <= RST_CURVE_KD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STRAIGHT_SPEED: cfg_q.straight_speed    <= cfg_data[DRIVE_W-1:0];
				CFG_CURVE_SPEED:    cfg_q.curve_speed       <= cfg_data[DRIVE_W-1:0];
				CFG_DIFF_GAIN:      cfg_q.differential_gain <= cfg_data[DGAIN_W-1:0];
				CFG_STRAIGHT_KP:    cfg_q.straight_kp       <= cfg_data[GAIN_W-1:0];
				CFG_STRAIGHT_KD:    cfg_q.straight_kd       <= cfg_data[GAIN_W-1:0];
				CFG_CURVE_KP:       cfg_q.curve_kp          <= cfg_data[GAIN_W-1:0];
				CFG_CURVE_KD:       cfg_q.curve_kd          <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// control step engine
	lfps_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.sns_valid      (sensor.valid),
		.sns_ready      (sensor.ready),
		.sensor_pattern (sensor.sensor_pattern),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.res            (res),
		.cfg            (cfg_q)
	);

	// result fields onto the channel
	assign result.servo_width = res.servo_width;
	assign result.left_drive  = res.left_drive;
	assign result.right_drive = res.right_drive;
	assign result.line_lost   = res.line_lost;

endmodule

`default_nettype wire

/* rtl/lfps_mul.sv */
// lfps_mul: shared signed multiplier with a registered product
// depends on lfps_pkg for the operand widths
`default_nettype none

module lfps_mul import lfps_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [MUL_A_W-1:0] op_a,
	input  wire logic signed [MUL_B_W-1:0] op_b,
	output logic signed [PROD_W-1:0]       product
);

	// one multiply per enabled cycle, product ready the cycle after issue and held otherwise
	always_ff @(posedge clk) begin
		if (en)
			product <= op_a * op_b;
	end

endmodule

`default_nettype wire

/* rtl/lfps_core.sv */
// lfps_core: sequencer and datapath of one PD control step around the shared multiplier
// depends on lfps_pkg and lfps_mul
`default_nettype none

module lfps_core import lfps_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sns_valid,
	output logic                      sns_ready,
	input  wire logic [PATTERN_W-1:0] sensor_pattern,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output lfps_result_t              res,
	input  wire lfps_cfg_t            cfg
);

	lfps_state_t state_q, state_d;

	logic signed [ERR_W-1:0]  prev_q, e_q, d_q;
	logic [LOST_W-1:0]        lost_q;
	logic [STRAIGHT_W-1:0]    straight_q;
	logic [GAIN_W-1:0]        kp_q, kd_q;
	logic signed [13:0]       acc_q;
	logic                     neg_q;
	logic signed [6:0]        steer_q;
	logic signed [7:0]        base_q;
	logic [SERVO_W-1:0]       servo_q;
	logic                     res_valid_q;
	lfps_result_t             res_q;

	logic signed [MUL_A_W-1:0] op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic signed [PROD_W-1:0]  product;

	logic accept, out_free, load_res, mul_en;

	lfps_mul u_mul (
		.clk     (clk),
		.en      (mul_en),
		.op_a    (op_a),
		.op_b    (op_b),
		.product (product)
	);

	assign accept   = sns_valid && sns_ready;
	assign out_free = !res_valid_q || res_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (sns_valid) state_d = ST_MUL_P;
			ST_MUL_P:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_SUM;
			ST_SUM:      state_d = ST_DIV_PD;
			ST_DIV_PD:   state_d = ST_STEER;
			ST_STEER:    state_d = ST_MUL_DIFF;
			ST_MUL_DIFF: state_d = ST_DIV_DIFF;
			ST_DIV_DIFF: state_d = ST_DRIVE;
			ST_DRIVE:    if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// magnitudes fed to the divide-by-ten multiply
	logic [13:0]        acc_mag;
	logic signed [14:0] diff_prod;
	logic [14:0]        diff_mag;

	assign acc_mag   = acc_q[13] ? 14'(-acc_q) : 14'(acc_q);
	assign diff_prod = product[14:0];
	assign diff_mag  = diff_prod[14] ? 15'(-diff_prod) : 15'(diff_prod);

	// sequencer outputs: handshake, multiplier operands, result load
	always_comb begin
		sns_ready = 1'b0;
		load_res  = 1'b0;
		mul_en    = 1'b1;
		op_a      = '0;
		op_b      = '0;
		case (state_q)
			ST_IDLE: sns_ready = 1'b1;
			ST_MUL_P: begin
				op_a = MUL_A_W'(e_q);
				op_b = {{(MUL_B_W-GAIN_W){1'b0}}, kp_q};
			end
			ST_MUL_D: begin
				op_a = MUL_A_W'(d_q);
				op_b = {{(MUL_B_W-GAIN_W){1'b0}}, kd_q};
			end
			ST_DIV_PD: begin
				op_a = {1'b0, acc_mag};
				op_b = RECIP_TEN;
			end
			ST_MUL_DIFF: begin
				op_a = MUL_A_W'(steer_q);
				op_b = {{(MUL_B_W-DGAIN_W){1'b0}}, cfg.differential_gain};
			end
			ST_DIV_DIFF: begin
				op_a = diff_mag;
				op_b = RECIP_TEN;
			end
			// quotient stays in the product register while the result side stalls
			ST_DRIVE: begin
				load_res = out_free;
				mul_en   = 1'b0;
			end
			default: ;
		endcase
	end

	// accept: pattern lookup, gain choice, jump rejection and lost counter update
	lfps_lookup_t            lk;
	logic signed [ERR_W-1:0] err0, err_sel;
	logic signed [5:0]       jump;
	logic                    reject, big;
	logic [LOST_W-1:0]       lost_d;

	always_comb begin
		lk      = lfps_lookup(sensor_pattern);
		err0    = lk.known ? lk.err : prev_q;
		big     = lfps_abs_err(err0) >= BIG_ERR;
		jump    = {err0[ERR_W-1], err0} - {prev_q[ERR_W-1], prev_q};
		reject  = (jump >= JUMP_LIMIT) || (jump <= -JUMP_LIMIT);
		err_sel = reject ? prev_q : err0;
		lost_d  = lost_q;
		if (lk.known)
			lost_d = lost_q >> 1;
		else if (sensor_pattern != '0 && lost_q != LOST_SAT)
			lost_d = lost_q + 1'b1;
	end

	// steer, servo width, straight count and base speed from the divided PD sum
	logic [7:0]        q1;
	logic signed [8:0] steer_full;
	logic signed [9:0] servo_full;
	logic [STRAIGHT_W-1:0] straight_d;
	logic signed [6:0] steer_c;
	logic signed [7:0] base_d;

	always_comb begin
		q1         = product[RECIP_SHIFT +: 8];
		steer_full = neg_q ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
		servo_full = SERVO_CENTRE + 10'(steer_full);
		if (steer_full <= STEER_NEAR && steer_full >= -STEER_NEAR)
			straight_d = (straight_q < STRAIGHT_CAP) ? straight_q + 1'b1 : straight_q;
		else
			straight_d = '0;
		if (steer_full > STEER_LIMIT)
			steer_c = 7'(STEER_LIMIT);
		else if (steer_full < -STEER_LIMIT)
			steer_c = 7'(-STEER_LIMIT);
		else
			steer_c = 7'(steer_full);
		if (straight_d >= STRAIGHT_NEEDED)
			base_d = $signed({1'b0, cfg.straight_speed});
		else if (lfps_abs_err(e_q) < BIG_ERR)
			base_d = $signed({1'b0, cfg.curve_speed});
		else
			base_d = $signed({1'b0, cfg.curve_speed}) - $signed(BEND_CUT);
	end

	// drives from the divided differential product
	logic [9:0]         q2;
	logic signed [10:0] diff;
	logic signed [11:0] left_full, right_full;
	logic               lost;
	lfps_result_t       res_d;

	always_comb begin
		q2         = product[RECIP_SHIFT +: 10];
		diff       = neg_q ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
		left_full  = 12'(base_q) + 12'(diff);
		right_full = 12'(base_q) - 12'(diff);
		lost       = lost_q >= LOST_LIMIT;
		res_d.servo_width = servo_q;
		res_d.line_lost   = lost;
		if (lost || left_full < 0)
			res_d.left_drive = '0;
		else if (left_full > DRIVE_MAX)
			res_d.left_drive = DRIVE_W'(DRIVE_MAX);
		else
			res_d.left_drive = DRIVE_W'(left_full);
		if (lost || right_full < 0)
			res_d.right_drive = '0;
		else if (right_full > DRIVE_MAX)
			res_d.right_drive = DRIVE_W'(DRIVE_MAX);
		else
			res_d.right_drive = DRIVE_W'(right_full);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			lost_q      <= '0;
			straight_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_q <= err_sel;
				lost_q <= lost_d;
			end
			if (state_q == ST_STEER)
				straight_q <= straight_d;
			if (load_res)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// working registers of the step
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q  <= err_sel;
			d_q  <= reject ? '0 : jump[ERR_W-1:0];
			kp_q <= big ? cfg.curve_kp : cfg.straight_kp;
			kd_q <= big ? cfg.curve_kd : cfg.straight_kd;
		end
		case (state_q)
			ST_MUL_D:    acc_q <= product[13:0];
			ST_SUM:      acc_q <= acc_q + product[13:0];
			ST_DIV_PD:   neg_q <= acc_q[13];
			ST_STEER: begin
				steer_q <= steer_c;
				base_q  <= base_d;
				if (servo_full > SERVO_MAX)
					servo_q <= SERVO_W'(SERVO_MAX);
				else if (servo_full < SERVO_MIN)
					servo_q <= SERVO_W'(SERVO_MIN);
				else
					servo_q <= SERVO_W'(servo_full);
			end
			ST_DIV_DIFF: neg_q <= diff_prod[14];
			default: ;
		endcase
		if (load_res)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// an accepted item starts the multiply sequence
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MUL_P)
		else $error("accepted item did not start the sequence");

	// stored error stays inside the table range
	a_prev_range: assert property (@(posedge clk) disable iff (!arst_n)
		(prev_q <= 5'sd11) && (prev_q >= -5'sd11))
		else $error("previous error out of range");

	// straight counter saturates at its cap
	a_straight_cap: assert property (@(posedge clk) disable iff (!arst_n)
		straight_q <= STRAIGHT_CAP)
		else $error("straight counter above cap");

	// a lost line stops both motors
	a_lost_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.line_lost) |-> (res_q.left_drive == '0 && res_q.right_drive == '0))
		else $error("drives not stopped on lost line");

	// servo width stays inside its travel
	a_servo_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.servo_width >= 8'd83 && res_q.servo_width <= 8'd158))
		else $error("servo width out of travel");
`endif

endmodule

`default_nettype wire
